/* sv/dtbs_pkg.sv */
package dtbs_pkg;

   // Table depth, the widths that follow from it, and the entry width.
   localparam int unsigned DEPTH  = 1024;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W  = ADDR_W + 1;
   localparam int unsigned SUM_W  = CNT_W + 1;
   localparam int unsigned DATA_W = 32;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   // Table memory access issued by the controller.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

/* sv/descending_table_binary_search_unit.sv */
// Binary search over a table of signed 32-bit entries loaded in descending order.
// Request beats arrive on the req_ stream: tuser carries the opcode (load, query,
// clear) and tdata the value. A load appends the value to the table, a clear
// empties it, and neither leaves the block busy nor produces a response beat.
// A load into a full table is dropped and sets a sticky overflow flag that only
// a clear or reset removes.
// A query produces exactly one beat on the rsp_ stream with the found bit, the
// echoed value and the current overflow flag. A query keeps the block busy
// through all its probes; their number is at most clog2(count) + 1, and so
// at most 11 for a full 1024-entry table. Each probe is one read of the single
// table RAM; the next probe address is chosen in the same cycle the read data
// is compared, so the RAM read port sets the pace.
// The response sits in an output register, so req_tready returns high while a
// response still waits for rsp_tready. If a second query finishes while the
// previous response is still stalled, the block holds that result and keeps
// req_tready low until the output register frees up.
// Synchronous reset empties the table, clears the overflow flag and drops any
// pending response. No clearing pass over the RAM is needed.
module descending_table_binary_search_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [0] found, [32:1] value_out, [33] overflow, rest zero
);
   import dtbs_pkg::*;

   mem_req_type        mem_req;
   logic [DATA_W-1:0]  mem_rd_data;
   logic               rsp_found;
   logic signed [31:0] rsp_value;
   logic               rsp_overflow;

   // Sequencer: table count, overflow flag, search bounds and response register.
   dtbs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_opcode   (req_tuser),
      .req_value    (req_tdata),
      .mem_req      (mem_req),
      .mem_rd_data  (mem_rd_data),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_found    (rsp_found),
      .rsp_value    (rsp_value),
      .rsp_overflow (rsp_overflow)
   );

   // The table itself. Entries are only read below the fill count, so the
   // contents need no initialization.
   dtbs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = {6'b0, rsp_overflow, rsp_value, rsp_found};

endmodule

/* sv/dtbs_ram.sv */
module dtbs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/dtbs_ctrl.sv */
module dtbs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic signed [31:0]          req_value,
   output dtbs_pkg::mem_req_type       mem_req,
   input  logic [dtbs_pkg::DATA_W-1:0] mem_rd_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic signed [31:0]          rsp_value,
   output logic                        rsp_overflow
);
   import dtbs_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   low_ff, low_in;
   logic [CNT_W-1:0]   high_ff, high_in;
   logic [ADDR_W-1:0]  mid_ff, mid_in;
   logic signed [31:0] sought_ff, sought_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               accept;
   opcode_type         op;
   logic [CNT_W-1:0]   count_m1;
   logic signed [31:0] probe;
   logic [SUM_W-1:0]   sum_up;
   logic [SUM_W-1:0]   sum_dn;
   logic [CNT_W-1:0]   mid_p1;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign op        = opcode_type'(req_opcode);
   assign count_m1  = count_ff - CNT_W'(1);
   assign probe     = mem_rd_data;
   assign mid_p1    = CNT_W'(mid_ff) + CNT_W'(1);
   // Next midpoint when the search moves to higher or to lower indices.
   assign sum_up    = SUM_W'(mid_ff) + SUM_W'(high_ff);
   assign sum_dn    = SUM_W'(low_ff) + SUM_W'(mid_ff) - SUM_W'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      sought_in    = sought_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_req      = '0;
      mem_req.wr_addr = count_ff[ADDR_W-1:0];
      mem_req.wr_data = req_value;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op)
                  OP_LOAD: begin
                     if (count_ff < CNT_W'(DEPTH)) begin
                        mem_req.wr_en = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  OP_QUERY: begin
                     sought_in = req_value;
                     found_in  = 1'b0;
                     low_in    = '0;
                     high_in   = count_ff;
                     if (count_ff != '0) begin
                        mid_in          = count_m1[ADDR_W:1];
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = count_m1[ADDR_W:1];
                        state_in        = S_PROBE;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PROBE: begin
            if (sought_ff == probe) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else if (sought_ff < probe) begin
               low_in = mid_p1;
               if (mid_p1 < high_ff) begin
                  mid_in          = sum_up[ADDR_W:1];
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = sum_up[ADDR_W:1];
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               high_in = CNT_W'(mid_ff);
               if (low_ff < CNT_W'(mid_ff)) begin
                  mid_in          = sum_dn[ADDR_W:1];
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = sum_dn[ADDR_W:1];
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_value_in = sought_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      low_ff       <= low_in;
      high_ff      <= high_in;
      mid_ff       <= mid_in;
      sought_ff    <= sought_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

/* sv/dtbs_checker.sv */
module dtbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import dtbs_pkg::*;

   // A stalled response beat stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response beat dropped while stalled");

   // A stalled response beat keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response payload changed while stalled");

   // Reset leaves the block idle with nothing to deliver.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // A query keeps the block busy for at least the cycle after it.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_QUERY) |=> !req_tready)
      else $error("request accepted during a search");

   // A new response is posted only as the block returns to idle.
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("response posted while search still running");

endmodule

bind descending_table_binary_search_unit dtbs_checker u_dtbs_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import dtbs_pkg::*;

   // Opcode 3 is left unused by the block. It must be swallowed without a
   // response and without touching the table.
   localparam logic [1:0] OP_IGNORED = 2'd3;

   // Stimulus stops once this many load, query and clear beats have gone in.
   localparam int unsigned ITEM_TARGET = 1600;
   // Percent of cycles in which either side idles outside the calm stretch.
   localparam int unsigned IDLE_PCT = 21;
   // A correct run never goes this long without a beat on either side.
   localparam int unsigned STALL_LIMIT = 2000;
   // Quiet cycles after the last response, to catch stray beats.
   localparam int unsigned SETTLE_CYCLES = 40;

   localparam longint VALUE_MAX = (64'sd1 <<< 31) - 1;
   localparam longint VALUE_MIN = -(64'sd1 <<< 31);

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] value
   logic [1:0]  req_tuser  = '0;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [0] found, [32:1] value_out, [33] overflow

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   descending_table_binary_search_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // What one query answers.
   typedef struct packed {
      logic        found;
      logic [31:0] value;
      logic        overflow;
   } lookup_answer_type;

   // One row of the directed part. Where typed is set, the answer to a query
   // is taken from the row instead of the shadow table.
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] value;
      logic        typed;
      logic        found;
      logic        overflow;
   } stim_row_type;

   // The directed part: lookups into an empty table at the value extremes,
   // an ignored opcode, a five-entry table spanning the full signed range,
   // a duplicated minimum, a clear, and finally an unsorted table where the
   // search may miss entries that are present.
   localparam int unsigned NUM_ROWS = 24;
   localparam stim_row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      '{OP_QUERY,   32'h0000_0000, 1'b1, 1'b0, 1'b0},
      '{OP_QUERY,   32'h8000_0000, 1'b1, 1'b0, 1'b0},
      '{OP_QUERY,   32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0},
      '{OP_IGNORED, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,   32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
      '{OP_LOAD,    32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{OP_LOAD,    32'd100,       1'b0, 1'b0, 1'b0},
      '{OP_LOAD,    32'd0,         1'b0, 1'b0, 1'b0},
      '{OP_LOAD,    32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{OP_LOAD,    32'h8000_0000, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,   32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,   32'h8000_0000, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,   32'd0,         1'b0, 1'b0, 1'b0},
      '{OP_QUERY,   32'd50,        1'b0, 1'b0, 1'b0},
      '{OP_QUERY,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{OP_LOAD,    32'h8000_0000, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,   32'h8000_0000, 1'b0, 1'b0, 1'b0},
      '{OP_CLEAR,   32'd0,         1'b0, 1'b0, 1'b0},
      '{OP_QUERY,   32'd100,       1'b1, 1'b0, 1'b0},
      '{OP_LOAD,    32'd7,         1'b0, 1'b0, 1'b0},
      '{OP_LOAD,    32'd9,         1'b0, 1'b0, 1'b0},
      '{OP_LOAD,    32'd3,         1'b0, 1'b0, 1'b0},
      '{OP_QUERY,   32'd9,         1'b0, 1'b0, 1'b0},
      '{OP_QUERY,   32'd3,         1'b0, 1'b0, 1'b0}
   };

   // Shadow copy of the block's table, fill level and sticky overflow bit.
   logic [31:0]       shadow_table [DEPTH];
   int unsigned       shadow_count    = 0;
   logic              shadow_overflow = 1'b0;
   lookup_answer_type pending_answers [$];

   // Values loaded since the last clear, used to aim queries at hits.
   int signed      loaded_vals [$];

   int             error_count = 0;
   int unsigned    items_sent  = 0;
   int unsigned    idle_cycles = 0;
   bit             calm        = 1'b0;

   // Binary search over the shadow table. Entries are meant to descend, so a
   // sought value above the probe keeps the lower half. The high bound is
   // exclusive and the probe sits at the lower middle.
   function automatic logic search_shadow(input logic signed [31:0] sought);
      int unsigned       lo;
      int unsigned       hi;
      int unsigned       mid;
      logic signed [31:0] probe;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid   = (lo + hi - 1) >> 1;
         probe = shadow_table[mid];
         if (sought == probe) return 1'b1;
         if (sought < probe) lo = mid + 1;
         else hi = mid;
      end
      return 1'b0;
   endfunction

   // Applies one accepted request beat to the shadow state. A query queues
   // the answer that the block owes for it.
   task automatic track_request(input logic [1:0] op, input logic [31:0] val);
      case (op)
         OP_LOAD: begin
            if (shadow_count < DEPTH) begin
               shadow_table[shadow_count] = val;
               shadow_count++;
            end else begin
               shadow_overflow = 1'b1;
            end
         end
         OP_CLEAR: begin
            shadow_count    = 0;
            shadow_overflow = 1'b0;
         end
         OP_QUERY: begin
            pending_answers.push_back('{found: search_shadow(val), value: val,
                                        overflow: shadow_overflow});
         end
         default: ;
      endcase
   endtask

   // Presents one request beat and holds it until the block takes it. Called
   // just after a falling edge; returns just after the falling edge that comes
   // after the accepting rising edge, so valid is assigned at most once per time step.
   task automatic send_item(input logic [1:0] op, input logic [31:0] val,
                            input bit typed = 1'b0, input bit t_found = 1'b0,
                            input bit t_ovf = 1'b0);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      do @(posedge clock); while (!req_tready);
      track_request(op, val);
      if (typed && op == OP_QUERY) begin
         void'(pending_answers.pop_back());
         pending_answers.push_back('{found: t_found, value: val, overflow: t_ovf});
      end
      if (op != OP_IGNORED) items_sent++;
      @(negedge clock);
   endtask

   // Loads n entries in descending order, starting at the maximum or at a
   // random value. A step of zero gives duplicates; the walk saturates at
   // the minimum, which then repeats.
   task automatic load_descending(input int unsigned n, input bit from_top,
                                  input int unsigned max_step);
      longint    v;
      int signed start;
      start = $urandom;
      v = from_top ? VALUE_MAX : longint'(start);
      repeat (n) begin
         send_item(OP_LOAD, v[31:0]);
         loaded_vals.push_back(int'(v));
         v -= longint'($urandom_range(max_step));
         if (v < VALUE_MIN) v = VALUE_MIN;
      end
   endtask

   // Half the queries hit a loaded value, some land next to one, the rest
   // are arbitrary or at the extremes.
   function automatic logic [31:0] pick_query_value();
      int unsigned roll;
      int unsigned idx;
      roll = $urandom_range(99);
      if (loaded_vals.size() > 0 && roll < 70) begin
         idx = $urandom_range(loaded_vals.size() - 1);
         if (roll < 50) return loaded_vals[idx];
         return loaded_vals[idx] + ($urandom_range(1) ? 1 : -1);
      end
      if (roll < 90) return $urandom;
      return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
   endfunction

   task automatic send_queries(input int unsigned n);
      repeat (n) send_item(OP_QUERY, pick_query_value());
   endtask

   task automatic clear_table();
      send_item(OP_CLEAR, $urandom);
      loaded_vals = {};
   endtask

   // The response side stalls at random outside the calm stretch. It is
   // driven at the falling edge so that it is stable at every rising edge.
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Every response beat is held against the oldest answer still owed.
   always @(posedge clock) begin
      lookup_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected response beat, rsp_tdata=%h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[0] !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[32:1] !== want.value) begin
               $error("value_out: expected %0d, got %0d",
                      $signed(want.value), $signed(rsp_tdata[32:1]));
               error_count++;
            end
            if (rsp_tdata[33] !== want.overflow) begin
               $error("overflow: expected %0d, got %0d", want.overflow, rsp_tdata[33]);
               error_count++;
            end
         end
      end
   end

   // Watchdog: ends the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned kind;
      int unsigned roll;
      int unsigned n;
      int unsigned step;
      int signed   noise_val;
      bit          full_done;
      full_done = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].found, DIRECTED_ROWS[i].overflow);
      end
      loaded_vals = {7, 9, 3};

      while (items_sent < ITEM_TARGET) begin
         // Neither side idles while this window of beats goes through.
         calm = (items_sent >= 100 && items_sent < 300);

         if (!full_done && items_sent >= 350) begin
            // Fill the table from the maximum down toward the minimum, push a few
            // loads past the end, search the full table, then clear and check
            // that the overflow bit went away.
            full_done = 1'b1;
            clear_table();
            load_descending(DEPTH, 1'b1, 8388607);
            repeat ($urandom_range(1, 4)) send_item(OP_LOAD, $urandom);
            send_queries(40);
            clear_table();
            send_queries(1);
         end else begin
            kind = $urandom_range(99);
            if (kind < 75) begin
               // A well-formed table with random content, mostly after a clear.
               if ($urandom_range(9) != 0) clear_table();
               roll = $urandom_range(99);
               if (roll < 30) n = $urandom_range(3);
               else if (roll < 90) n = $urandom_range(4, 40);
               else n = $urandom_range(41, 150);
               case ($urandom_range(2))
                  0: step = 3;
                  1: step = 1 << 20;
                  default: step = 1 << 26;
               endcase
               load_descending(n, $urandom_range(7) == 0, step);
               send_queries($urandom_range(2, 8));
            end else if (kind < 90) begin
               // An unsorted table: the search may miss entries.
               if ($urandom_range(1)) clear_table();
               repeat ($urandom_range(1, 12)) begin
                  noise_val = $urandom;
                  send_item(OP_LOAD, noise_val);
                  loaded_vals.push_back(noise_val);
               end
               send_queries($urandom_range(2, 5));
            end else begin
               // Noise: unused opcodes mixed with stray queries and loads.
               repeat ($urandom_range(1, 4)) begin
                  case ($urandom_range(3))
                     0, 1: send_item(OP_IGNORED, $urandom);
                     2: send_item(OP_QUERY, $urandom);
                     default: send_item(OP_LOAD, $urandom);
                  endcase
               end
            end
         end
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // Drain every owed answer, then give stray beats a chance to show up.
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
